@@ rtl/core/pcx_pkg.sv @@
// Package: types, constants and helpers for the PCX run-length planar decoder.
package pcx_pkg;

    localparam int unsigned LINE_STORE_BYTES = 128;
    localparam int unsigned STORE_AW         = $clog2(LINE_STORE_BYTES);
    localparam logic [7:0]  RUN_BASE         = 8'hC0;
    localparam logic [7:0]  MAX_LINE_OUT     = 8'h80;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_PLANE  = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_LINES  = 3'd3;
    localparam logic [2:0] REG_PIXELS = 3'd4;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_bytes;
        logic [2:0]  byte_count;
        logic        image_end;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    typedef struct packed {
        logic        eight_bit_mode;
        logic [5:0]  plane_bytes_per_line;
        logic [7:0]  line_width_bytes;
        logic [9:0]  line_count;
        logic [19:0] pixel_total;
    } cfg_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic take_byte;    // latch the accepted request
        logic decode;       // decode the latched request, update progress
        logic emit_run;     // send one 8-bit run word
        logic store_write;  // write one planar byte
        logic merge_start;  // load merge address
        logic merge_read;   // issue merge read (one plane per cycle)
        logic merge_emit;   // send one merged word
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic drop;         // byte produces nothing
        logic eight;        // eight-bit path
        logic run_done;     // run bytes all sent / stored
        logic line_full;    // store reached line target
        logic merge_done;   // last merge word sent
        logic merge_empty;  // zero-width line
        logic plane_last;   // fourth plane read issued
        logic rd_pend;      // plane read still landing
    } sts_t;

    function automatic logic [7:0] merge_byte(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] a,
                                              input logic [1:0] i);
        logic [2:0] hb;
        logic [2:0] lb;
        hb = 3'd7 - {i, 1'b0};
        lb = 3'd6 - {i, 1'b0};
        return {a[lb], b[lb], g[lb], r[lb], a[hb], b[hb], g[hb], r[hb]};
    endfunction

endpackage

@@ rtl/core/pcx_rle_planar_decoder_top.sv @@
// 8-bit: accept, decode, then one send per run word of up to 4 bytes; a literal is one send.
// Planar: accept, decode, one store per byte, then a line check; a full line is then merged:
// a merge start, then per word 4 plane reads, a settle and a send. Markers and ignored
// requests end after accept and decode. Output words are registered.
// A new request is taken only once the last is done; output stalls hold the controller.
// Reset: synchronous active-low aresetn; registers to defaults, idle; line store kept.
module pcx_rle_planar_decoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcx_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pcx_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pcx_pkg::cfg_item_t  cfg_data
);

    pcx_pkg::cfg_t cfg_reg;
    pcx_pkg::cmd_t cmd;
    pcx_pkg::sts_t sts;
    logic          out_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.eight_bit_mode       <= 1'b1;
            cfg_reg.plane_bytes_per_line <= 6'd32;
            cfg_reg.line_width_bytes     <= 8'd128;
            cfg_reg.line_count           <= 10'd256;
            cfg_reg.pixel_total          <= 20'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_data.index)
                pcx_pkg::REG_MODE:   cfg_reg.eight_bit_mode       <= cfg_data.data[0];
                pcx_pkg::REG_PLANE:  cfg_reg.plane_bytes_per_line <= cfg_data.data[5:0];
                pcx_pkg::REG_WIDTH:  cfg_reg.line_width_bytes     <= cfg_data.data[7:0];
                pcx_pkg::REG_LINES:  cfg_reg.line_count           <= cfg_data.data[9:0];
                pcx_pkg::REG_PIXELS: cfg_reg.pixel_total          <= cfg_data.data[19:0];
                default: ;
            endcase
        end
    end

    pcx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcx_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .out_busy (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/core/pcx_ctrl.sv @@
// Controller state machine for the PCX decoder.
module pcx_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          out_busy,
    input  pcx_pkg::sts_t sts,
    output pcx_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DEC    = 6'b000010,
        ST_RUN    = 6'b000100,
        ST_MSTART = 6'b001000,
        ST_MREAD  = 6'b010000,
        ST_MEMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_byte = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.decode = 1'b1;
                if (sts.drop) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.eight) begin
                    if (!out_busy) begin
                        cmd.emit_run = 1'b1;
                        if (sts.run_done) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (sts.run_done) begin
                    state_next = sts.line_full ? ST_MSTART : ST_IDLE;
                end else begin
                    cmd.store_write = 1'b1;
                end
            end
            ST_MSTART: begin
                cmd.merge_start = 1'b1;
                state_next = sts.merge_empty ? ST_IDLE : ST_MREAD;
            end
            ST_MREAD: begin
                cmd.merge_read = 1'b1;
                if (sts.plane_last) begin
                    state_next = ST_MEMIT;
                end
            end
            ST_MEMIT: begin
                if (!out_busy && !sts.rd_pend) begin
                    cmd.merge_emit = 1'b1;
                    state_next = sts.merge_done ? ST_IDLE : ST_MREAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_byte |-> state_reg == ST_IDLE)
        else $error("request taken while busy");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_run || cmd.merge_emit) |-> !out_busy)
        else $error("emit into full output");

endmodule

@@ rtl/core/pcx_datapath.sv @@
// Datapath: run decode, counters, line store and plane merge, output register.
module pcx_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcx_pkg::in_item_t   s_data,
    input  pcx_pkg::cfg_t       cfg,
    input  pcx_pkg::cmd_t       cmd,
    output pcx_pkg::sts_t       sts,
    output logic                out_busy,
    output logic                m_valid,
    input  logic                m_ready,
    output pcx_pkg::out_item_t  m_data
);

    logic [7:0]  store_mem [pcx_pkg::LINE_STORE_BYTES];
    logic [7:0]  rd_data_reg;
    logic        rd_ok_reg;

    logic [7:0]  code_reg;
    logic        first_reg;
    logic        run_pending_reg;
    logic [5:0]  pend_len_reg;
    logic [19:0] pixels_left_reg;
    logic [9:0]  lines_left_reg;
    logic        image_done_reg;
    logic [7:0]  store_fill_reg;
    logic [6:0]  cnt_reg;          // bytes still to emit/store
    logic        end_reg;

    logic [7:0]  col_reg;
    logic [7:0]  rem_reg;
    logic [1:0]  plane_reg;
    logic [1:0]  plane_d_reg;
    logic        rd_pend_reg;
    logic [7:0]  pl_reg [4];

    logic        valid_reg;
    pcx_pkg::out_item_t data_reg;

    // decode of the latched request; a first request sees cleared progress
    logic        active;
    logic        pend_eff;
    logic        is_marker;
    logic [6:0]  count;
    logic [8:0]  target;
    logic [8:0]  lim;
    logic [8:0]  fill_ext;

    assign target   = {1'b0, cfg.plane_bytes_per_line, 2'b00};
    assign fill_ext = first_reg ? 9'd0 : {1'b0, store_fill_reg};
    assign active   = first_reg ? (cfg.eight_bit_mode ? (cfg.pixel_total != '0)
                                                      : (cfg.line_count != '0))
                                : !image_done_reg;
    assign pend_eff  = !first_reg && run_pending_reg;
    assign is_marker = !pend_eff && (code_reg > pcx_pkg::RUN_BASE);
    assign count     = pend_eff ? {1'b0, pend_len_reg} : 7'd1;
    always_comb begin
        lim = (fill_ext < target) ? target - fill_ext : 9'd0;
        if (lim == 9'd0) begin
            lim = 9'd1;
        end
    end

    logic [19:0] px_base;
    logic [6:0]  k8;
    logic [6:0]  kp;
    assign px_base = first_reg ? cfg.pixel_total : pixels_left_reg;
    assign k8 = ({13'd0, count} < px_base) ? count : px_base[6:0];
    assign kp = ({2'd0, count} < lim) ? count : lim[6:0];

    // merge geometry
    logic [7:0]  width_c;
    logic [9:0]  rd_addr;
    logic [9:0]  pstep;
    assign width_c = (cfg.line_width_bytes > pcx_pkg::MAX_LINE_OUT) ? pcx_pkg::MAX_LINE_OUT
                                                                     : cfg.line_width_bytes;
    always_comb begin
        pstep = {4'd0, cfg.plane_bytes_per_line};
        case (plane_reg)
            2'd0: rd_addr = {2'd0, col_reg};
            2'd1: rd_addr = {2'd0, col_reg} + pstep;
            2'd2: rd_addr = {2'd0, col_reg} + {pstep[8:0], 1'b0};
            default: rd_addr = {2'd0, col_reg} + {pstep[8:0], 1'b0} + pstep;
        endcase
    end

    logic [31:0] mword;
    logic [2:0]  mcount;
    always_comb begin
        mword = {pcx_pkg::merge_byte(pl_reg[0], pl_reg[1], pl_reg[2], pl_reg[3], 2'd3),
                 pcx_pkg::merge_byte(pl_reg[0], pl_reg[1], pl_reg[2], pl_reg[3], 2'd2),
                 pcx_pkg::merge_byte(pl_reg[0], pl_reg[1], pl_reg[2], pl_reg[3], 2'd1),
                 pcx_pkg::merge_byte(pl_reg[0], pl_reg[1], pl_reg[2], pl_reg[3], 2'd0)};
        mcount = (rem_reg >= 8'd4) ? 3'd4 : 3'd2;
        if (mcount == 3'd2) begin
            mword[31:16] = 16'd0;
        end
    end

    assign sts.drop        = !active || is_marker || (cfg.eight_bit_mode && k8 == 7'd0);
    assign sts.eight       = cfg.eight_bit_mode;
    assign sts.run_done    = (cnt_reg == 7'd0) || (cfg.eight_bit_mode && cnt_reg <= 7'd4);
    assign sts.line_full   = {1'b0, store_fill_reg} >= target;
    assign sts.merge_done  = rem_reg <= 8'd4;
    assign sts.merge_empty = (width_c == 8'd0);
    assign sts.plane_last  = (plane_reg == 2'd3);
    assign sts.rd_pend     = rd_pend_reg;

    assign out_busy = valid_reg && !m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_byte) begin
            code_reg  <= s_data.code_byte;
            first_reg <= s_data.first;
        end
        if (cmd.store_write && store_fill_reg < 8'(pcx_pkg::LINE_STORE_BYTES)) begin
            store_mem[store_fill_reg[pcx_pkg::STORE_AW-1:0]] <= code_reg;
        end
        rd_ok_reg <= rd_addr < 10'(pcx_pkg::LINE_STORE_BYTES);
        rd_data_reg <= store_mem[rd_addr[pcx_pkg::STORE_AW-1:0]];
        if (rd_pend_reg) begin
            pl_reg[plane_d_reg] <= rd_ok_reg ? rd_data_reg : 8'd0;
        end
    end

    logic [6:0] emit_n;
    assign emit_n = (cnt_reg >= 7'd4) ? 7'd4 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_pending_reg <= 1'b0;
            pend_len_reg    <= '0;
            pixels_left_reg <= '0;
            lines_left_reg  <= '0;
            image_done_reg  <= 1'b1;
            store_fill_reg  <= '0;
            cnt_reg         <= '0;
            end_reg         <= 1'b0;
            valid_reg       <= 1'b0;
            col_reg         <= '0;
            rem_reg         <= '0;
            plane_reg       <= '0;
            plane_d_reg     <= '0;
            rd_pend_reg     <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.merge_read;
            plane_d_reg <= plane_reg;
            if (valid_reg && m_ready) begin
                valid_reg <= 1'b0;
            end
            if (cmd.decode) begin
                if (first_reg) begin
                    run_pending_reg <= 1'b0;
                    pend_len_reg    <= '0;
                    store_fill_reg  <= '0;
                    pixels_left_reg <= cfg.pixel_total;
                    lines_left_reg  <= cfg.line_count;
                end
                image_done_reg <= !active;
                if (active) begin
                    if (is_marker) begin
                        run_pending_reg <= 1'b1;
                        pend_len_reg    <= 6'(code_reg - pcx_pkg::RUN_BASE);
                    end else begin
                        run_pending_reg <= 1'b0;
                        pend_len_reg    <= '0;
                        if (cfg.eight_bit_mode) begin
                            cnt_reg         <= k8;
                            pixels_left_reg <= px_base - {13'd0, k8};
                            end_reg         <= px_base == {13'd0, k8};
                            if (px_base == {13'd0, k8}) begin
                                image_done_reg <= 1'b1;
                            end
                        end else begin
                            cnt_reg <= kp;
                            end_reg <= 1'b0;
                        end
                    end
                end
            end
            if (cmd.emit_run) begin
                data_reg.pixel_bytes <= {4{code_reg}} & ~(32'hFFFF_FFFF << {emit_n[2:0], 3'b000});
                data_reg.byte_count  <= emit_n[2:0];
                data_reg.image_end   <= end_reg && cnt_reg <= 7'd4;
                valid_reg            <= 1'b1;
                cnt_reg              <= cnt_reg - emit_n;
            end
            if (cmd.store_write) begin
                store_fill_reg <= store_fill_reg + 8'd1;
                cnt_reg        <= cnt_reg - 7'd1;
            end
            if (cmd.merge_start) begin
                store_fill_reg <= '0;
                lines_left_reg <= lines_left_reg - 10'd1;
                end_reg        <= lines_left_reg == 10'd1;
                if (lines_left_reg == 10'd1) begin
                    image_done_reg <= 1'b1;
                end
                col_reg   <= '0;
                rem_reg   <= width_c;
                plane_reg <= '0;
            end
            if (cmd.merge_read) begin
                plane_reg <= plane_reg + 2'd1;
            end
            if (cmd.merge_emit) begin
                data_reg.pixel_bytes <= mword;
                data_reg.byte_count  <= mcount;
                data_reg.image_end   <= end_reg && rem_reg <= 8'd4;
                valid_reg            <= 1'b1;
                rem_reg              <= (rem_reg >= 8'd4) ? rem_reg - 8'd4 : 8'd0;
                col_reg              <= col_reg + 8'd1;
            end
        end
    end

endmodule
